### rtl/fawr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fawr_pkg
// Shared types and constants for the frame allocator with replacement.
// ----------------------------------------------------------------------------
package fawr_pkg;
    localparam int NUM_FRAMES = 16;
    localparam int FRAME_BITS = 4;
    localparam int RING_DEPTH = 64;
    localparam int RING_BITS  = 6;
    localparam int COUNT_BITS = 16;
    localparam int TICK_BITS  = 32;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_TOUCH   = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        POL_LRU  = 2'd0,
        POL_FIFO = 2'd1,
        POL_LFU  = 2'd2,
        POL_MFU  = 2'd3
    } policy_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FREE_SCAN,
        ST_FREE_GIVE,
        ST_VIC_START,
        ST_VIC_SCAN,
        ST_FIFO_READ,
        ST_FIFO_CHECK,
        ST_VIC_GIVE,
        ST_RESTAMP,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture input beat
        logic do_touch;
        logic do_release;
        logic scan_clear;   // restart scan at frame 0
        logic scan_step;    // advance scan index
        logic scan_to_next; // scan index := grant frame + 1
        logic give_free;    // grant scan frame as free
        logic best_clear;
        logic give_best;    // grant best as victim
        logic fifo_pop;     // pop ring head into read register
        logic give_fifo;    // grant popped frame
        logic give_err;     // grant lowest untaken with error
        logic restamp;      // restamp list entry at restamp index
        logic emit;         // push result to output register
        logic set_exhaust;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_alloc;
        logic is_touch;
        logic is_release;
        logic req_zero;
        logic scan_done;    // scan index past last frame
        logic scan_free;    // scan frame is free
        logic all_given;    // number given reaches request
        logic fifo_sel;
        logic ring_empty;
        logic fifo_ok;      // popped record usable
        logic restamp_done;
        logic out_free;     // output register can take a beat
        logic emit_done;
        logic exhausted;
    } dp_sts_t;
endpackage

### rtl/fawr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fawr_ctrl
// Sequencer for allocate, touch and release.
// ----------------------------------------------------------------------------
module fawr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fawr_pkg::dp_sts_t sts,
    output fawr_pkg::dp_cmd_t cmd
);
    fawr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fawr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            fawr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next = fawr_pkg::ST_FREE_SCAN;
                end
            end
            fawr_pkg::ST_FREE_SCAN:
            begin
                if (sts.is_touch)
                begin
                    cmd.do_touch = 1'b1;
                    state_next = fawr_pkg::ST_IDLE;
                end
                else if (sts.is_release)
                begin
                    cmd.do_release = 1'b1;
                    state_next = fawr_pkg::ST_IDLE;
                end
                else if (!sts.is_alloc || sts.req_zero)
                begin
                    state_next = fawr_pkg::ST_IDLE;
                end
                else if (sts.scan_done)
                begin
                    cmd.set_exhaust = 1'b1;
                    state_next = sts.all_given ? fawr_pkg::ST_RESTAMP
                                               : fawr_pkg::ST_VIC_START;
                end
                else if (sts.all_given)
                begin
                    // request filled; frames remain free only if scan finds one
                    if (sts.scan_free)
                    begin
                        state_next = fawr_pkg::ST_OUT;
                    end
                    else
                    begin
                        cmd.scan_step = 1'b1;
                    end
                end
                else if (sts.scan_free)
                begin
                    cmd.give_free = 1'b1;
                    state_next = fawr_pkg::ST_FREE_GIVE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            fawr_pkg::ST_FREE_GIVE:
            begin
                cmd.scan_to_next = 1'b1;
                state_next = fawr_pkg::ST_FREE_SCAN;
            end
            fawr_pkg::ST_VIC_START:
            begin
                if (sts.all_given)
                begin
                    state_next = fawr_pkg::ST_RESTAMP;
                end
                else if (sts.fifo_sel)
                begin
                    state_next = fawr_pkg::ST_FIFO_READ;
                end
                else
                begin
                    cmd.scan_clear = 1'b1;
                    cmd.best_clear = 1'b1;
                    state_next = fawr_pkg::ST_VIC_SCAN;
                end
            end
            fawr_pkg::ST_VIC_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.give_best = 1'b1;
                    state_next = fawr_pkg::ST_VIC_GIVE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            fawr_pkg::ST_FIFO_READ:
            begin
                if (sts.ring_empty)
                begin
                    cmd.give_err = 1'b1;
                    state_next = fawr_pkg::ST_VIC_GIVE;
                end
                else
                begin
                    cmd.fifo_pop = 1'b1;
                    state_next = fawr_pkg::ST_FIFO_CHECK;
                end
            end
            fawr_pkg::ST_FIFO_CHECK:
            begin
                if (sts.fifo_ok)
                begin
                    cmd.give_fifo = 1'b1;
                    state_next = fawr_pkg::ST_VIC_GIVE;
                end
                else
                begin
                    state_next = fawr_pkg::ST_FIFO_READ;
                end
            end
            fawr_pkg::ST_VIC_GIVE:
            begin
                state_next = fawr_pkg::ST_VIC_START;
            end
            fawr_pkg::ST_RESTAMP:
            begin
                if (sts.restamp_done)
                begin
                    state_next = fawr_pkg::ST_OUT;
                end
                else
                begin
                    cmd.restamp = 1'b1;
                end
            end
            fawr_pkg::ST_OUT:
            begin
                if (sts.emit_done)
                begin
                    state_next = fawr_pkg::ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            default:
            begin
                state_next = fawr_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

### rtl/fawr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fawr_dp
// Frame tables, touch ring, grant list and output register.
// ----------------------------------------------------------------------------
module fawr_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  fawr_pkg::dp_cmd_t cmd,
    output fawr_pkg::dp_sts_t sts,
    input  logic              policy_we,
    input  logic [1:0]        policy_wdata,
    input  logic [1:0]        action,
    input  logic [3:0]        frame,
    input  logic [4:0]        count,
    input  logic [31:0]       tick,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        granted_frame,
    output logic              was_victim,
    output logic              last_frame,
    output logic              error
);
    localparam int FB = fawr_pkg::FRAME_BITS;
    localparam int NF = fawr_pkg::NUM_FRAMES;
    localparam int RB = fawr_pkg::RING_BITS;
    localparam int CB = fawr_pkg::COUNT_BITS;
    localparam int TB = fawr_pkg::TICK_BITS;
    localparam logic [CB-1:0] CMAX = '1;

    logic [1:0]      policy_reg;
    logic [NF-1:0]   busy_reg;
    logic [TB-1:0]   tick_tab_reg [NF];
    logic [CB-1:0]   cnt_tab_reg  [NF];
    logic [FB-1:0]   ring_mem     [fawr_pkg::RING_DEPTH];
    logic [RB-1:0]   head_reg;
    logic [RB:0]     fill_reg;

    logic [1:0]      act_reg;
    logic [FB-1:0]   frm_reg;
    logic [FB:0]     req_reg;
    logic [TB-1:0]   tk_reg;
    logic [FB:0]     scan_reg;
    logic [NF-1:0]   taken_reg;
    logic [FB-1:0]   list_reg [NF];
    logic [NF-1:0]   vic_reg, err_reg;
    logic [FB:0]     ng_reg, rs_reg, em_reg;
    logic [FB-1:0]   best_reg;
    logic            best_ok_reg;
    logic [FB-1:0]   pop_reg;
    logic            exh_reg;

    logic            ov_reg;
    logic [FB-1:0]   o_frame_reg;
    logic            o_vic_reg, o_last_reg, o_err_reg;

    logic [FB-1:0]   scan_idx;
    logic            better;
    logic            push_en;
    logic [FB-1:0]   push_frame;
    logic            stamp_en, restamp_en;
    logic [FB-1:0]   stamp_frame;
    logic [FB-1:0]   low_untaken;
    logic [FB-1:0]   give_frame;
    logic            give_en;
    logic [RB-1:0]   push_addr;

    assign scan_idx = scan_reg[FB-1:0];

    always_comb
    begin
        low_untaken = '0;
        for (int i = NF - 1; i >= 0; i--)
        begin
            if (!taken_reg[i])
            begin
                low_untaken = FB'(i);
            end
        end
    end

    always_comb
    begin
        case (fawr_pkg::policy_t'(policy_reg))
            fawr_pkg::POL_LRU: better = tick_tab_reg[scan_idx] < tick_tab_reg[best_reg];
            fawr_pkg::POL_LFU: better = cnt_tab_reg[scan_idx] < cnt_tab_reg[best_reg];
            default:           better = cnt_tab_reg[scan_idx] > cnt_tab_reg[best_reg];
        endcase
    end

    always_comb
    begin
        give_en = cmd.give_free | cmd.give_best | cmd.give_fifo | cmd.give_err;
        if (cmd.give_free)
        begin
            give_frame = scan_idx;
        end
        else if (cmd.give_best)
        begin
            give_frame = best_reg;
        end
        else if (cmd.give_fifo)
        begin
            give_frame = pop_reg;
        end
        else
        begin
            give_frame = low_untaken;
        end
        stamp_en    = cmd.do_touch | cmd.give_free | cmd.restamp;
        restamp_en  = cmd.restamp;
        stamp_frame = cmd.do_touch ? frm_reg
                    : (cmd.restamp ? list_reg[rs_reg[FB-1:0]] : scan_idx);
        push_en     = stamp_en;
        push_frame  = stamp_frame;
        push_addr   = (fill_reg[RB]) ? head_reg : RB'(head_reg + fill_reg[RB-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            ring_mem[push_addr] <= push_frame;
        end
        if (cmd.fifo_pop)
        begin
            pop_reg <= ring_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= '0;
            busy_reg   <= '0;
            head_reg   <= '0;
            fill_reg   <= '0;
            act_reg    <= '0;
            ov_reg     <= 1'b0;
            for (int i = 0; i < NF; i++)
            begin
                tick_tab_reg[i] <= '0;
                cnt_tab_reg[i]  <= '0;
            end
        end
        else
        begin
            if (policy_we)
            begin
                policy_reg <= policy_wdata;
            end
            if (cmd.load)
            begin
                act_reg <= action;
            end
            if (stamp_en)
            begin
                tick_tab_reg[stamp_frame] <= tk_reg;
                if (restamp_en)
                begin
                    cnt_tab_reg[stamp_frame] <= CB'(1);
                end
                else if (cnt_tab_reg[stamp_frame] != CMAX)
                begin
                    cnt_tab_reg[stamp_frame] <= cnt_tab_reg[stamp_frame] + CB'(1);
                end
            end
            if (push_en)
            begin
                if (fill_reg[RB])
                begin
                    head_reg <= head_reg + RB'(1);
                end
                else
                begin
                    fill_reg <= fill_reg + (RB+1)'(1);
                end
            end
            else if (cmd.fifo_pop)
            begin
                head_reg <= head_reg + RB'(1);
                fill_reg <= fill_reg - (RB+1)'(1);
            end
            if (cmd.do_release)
            begin
                busy_reg[frm_reg] <= 1'b0;
            end
            if (cmd.emit)
            begin
                busy_reg[list_reg[em_reg[FB-1:0]]] <= 1'b1;
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frm_reg   <= frame;
            tk_reg    <= tick;
            req_reg   <= (count > 5'(NF)) ? (FB+1)'(NF) : count;
            taken_reg <= '0;
            ng_reg    <= '0;
            rs_reg    <= '0;
            em_reg    <= '0;
            exh_reg   <= 1'b0;
        end
        if (cmd.scan_clear)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + (FB+1)'(1);
        end
        else if (cmd.scan_to_next)
        begin
            scan_reg <= scan_reg + (FB+1)'(1);
        end
        if (cmd.best_clear)
        begin
            best_ok_reg <= 1'b0;
            best_reg    <= '0;
        end
        else if (cmd.scan_step && !taken_reg[scan_idx])
        begin
            if (!best_ok_reg || better)
            begin
                best_reg    <= scan_idx;
                best_ok_reg <= 1'b1;
            end
        end
        if (give_en)
        begin
            list_reg[ng_reg[FB-1:0]] <= give_frame;
            vic_reg[ng_reg[FB-1:0]]  <= !cmd.give_free;
            err_reg[ng_reg[FB-1:0]]  <= cmd.give_err;
            taken_reg[give_frame]    <= 1'b1;
            ng_reg <= ng_reg + (FB+1)'(1);
        end
        if (cmd.set_exhaust)
        begin
            exh_reg <= 1'b1;
        end
        if (cmd.restamp)
        begin
            rs_reg <= rs_reg + (FB+1)'(1);
        end
        if (cmd.emit)
        begin
            o_frame_reg <= list_reg[em_reg[FB-1:0]];
            o_vic_reg   <= vic_reg[em_reg[FB-1:0]];
            o_err_reg   <= err_reg[em_reg[FB-1:0]];
            o_last_reg  <= (em_reg + (FB+1)'(1)) == ng_reg;
            em_reg      <= em_reg + (FB+1)'(1);
        end
    end

    always_comb
    begin
        sts.is_alloc     = act_reg == fawr_pkg::ACT_ALLOC;
        sts.is_touch     = act_reg == fawr_pkg::ACT_TOUCH;
        sts.is_release   = act_reg == fawr_pkg::ACT_RELEASE;
        sts.req_zero     = req_reg == '0;
        sts.scan_done    = scan_reg == (FB+1)'(NF);
        sts.scan_free    = !busy_reg[scan_idx];
        sts.all_given    = ng_reg == req_reg;
        sts.fifo_sel     = policy_reg == fawr_pkg::POL_FIFO;
        sts.ring_empty   = fill_reg == '0;
        sts.fifo_ok      = !taken_reg[pop_reg];
        sts.restamp_done = rs_reg == ng_reg;
        sts.out_free     = !ov_reg || out_ready;
        sts.emit_done    = em_reg == ng_reg;
        sts.exhausted    = exh_reg;
    end

    assign out_valid     = ov_reg;
    assign granted_frame = o_frame_reg;
    assign was_victim    = o_vic_reg;
    assign last_frame    = o_last_reg;
    assign error         = o_err_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (RB+1)'(fawr_pkg::RING_DEPTH))
        else $error("ring fill overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fifo_pop |-> fill_reg != '0)
        else $error("pop from empty ring");
    a_give_untaken: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.give_best |-> !taken_reg[best_reg])
        else $error("victim already given");
endmodule

### rtl/frame_allocator_with_replacement_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_allocator_with_replacement_core
// Frame allocator with LRU/FIFO/LFU/MFU replacement.
// ----------------------------------------------------------------------------
// Touch and release act in the scan state and return to idle. Allocate scans the frames
// for free slots, granting each free one and stepping past busy ones, then picks each
// value-policy victim by a full frame scan or each FIFO victim from the ring head,
// skipping granted records; it restamps every grant (only when the free frames ran out)
// and sends one result beat per cycle while out_ready is high. One item at a time.
// Reset clears all tables, ring pointers and policy; the ring body is not cleared.
module frame_allocator_with_replacement_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [3:0]  frame,
    input  logic [4:0]  count,
    input  logic [31:0] tick,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  granted_frame,
    output logic        was_victim,
    output logic        last_frame,
    output logic        error
);
    fawr_pkg::dp_cmd_t cmd;
    fawr_pkg::dp_sts_t sts;

    fawr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fawr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .policy_we     (cfg_we),
        .policy_wdata  (cfg_wdata),
        .action        (action),
        .frame         (frame),
        .count         (count),
        .tick          (tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_frame (granted_frame),
        .was_victim    (was_victim),
        .last_frame    (last_frame),
        .error         (error)
    );
endmodule

### test/frame_allocator_with_replacement_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_allocator_with_replacement_core_tb
// Drives allocate, touch and release beats under all four replacement
// policies, with random idling on both sides, and checks every grant beat
// against a behavioral model of the frame tables and the touch ring.
// ----------------------------------------------------------------------------

typedef struct {
    logic [3:0] frame_idx;
    logic       victim;
    logic       last;
    logic       err;
} grant_t;

class frame_grant_board;
    fawr_pkg::policy_t pol;
    bit               busy[fawr_pkg::NUM_FRAMES];
    bit [31:0]        last_tick[fawr_pkg::NUM_FRAMES];
    bit [15:0]        uses[fawr_pkg::NUM_FRAMES];
    bit [3:0]         ring[fawr_pkg::RING_DEPTH];
    int               head;
    int               fill;
    grant_t           grants_due[$];
    int               errors;

    function new();
        pol = fawr_pkg::POL_LRU;
        head = 0;
        fill = 0;
        errors = 0;
        foreach (busy[i])
        begin
            busy[i] = 0;
            last_tick[i] = 0;
            uses[i] = 0;
        end
    endfunction

    function void ring_push(int f);
        if (fill >= fawr_pkg::RING_DEPTH)
        begin
            head = (head + 1) % fawr_pkg::RING_DEPTH;
            fill = fawr_pkg::RING_DEPTH - 1;
        end
        ring[(head + fill) % fawr_pkg::RING_DEPTH] = f[3:0];
        fill++;
    endfunction

    function void stamp(int f, bit [31:0] t);
        last_tick[f] = t;
        if (uses[f] != 16'hFFFF)
            uses[f]++;
        ring_push(f);
    endfunction

    function int pick_by_value(bit taken[fawr_pkg::NUM_FRAMES]);
        int best;
        bit better;
        best = fawr_pkg::NUM_FRAMES;
        for (int f = 0; f < fawr_pkg::NUM_FRAMES; f++)
        begin
            if (taken[f])
                continue;
            if (best == fawr_pkg::NUM_FRAMES)
            begin
                best = f;
                continue;
            end
            if (pol == fawr_pkg::POL_LRU)
                better = last_tick[f] < last_tick[best];
            else if (pol == fawr_pkg::POL_LFU)
                better = uses[f] < uses[best];
            else
                better = uses[f] > uses[best];
            if (better)
                best = f;
        end
        return (best < fawr_pkg::NUM_FRAMES) ? best : 0;
    endfunction

    // every record looked at is popped, used or not
    function int pick_oldest(bit taken[fawr_pkg::NUM_FRAMES], output bit err);
        int v;
        while (fill > 0)
        begin
            v = ring[head];
            head = (head + 1) % fawr_pkg::RING_DEPTH;
            fill--;
            if (!taken[v])
            begin
                err = 0;
                return v;
            end
        end
        err = 1;
        for (int f = 0; f < fawr_pkg::NUM_FRAMES; f++)
            if (!taken[f])
                return f;
        return 0;
    endfunction

    function void note_beat(fawr_pkg::action_t act, int frm, int cnt, bit [31:0] t);
        bit     taken[fawr_pkg::NUM_FRAMES];
        grant_t given[$];
        grant_t g;
        int     n;
        int     f;
        bit     e;
        if (act == fawr_pkg::ACT_TOUCH)
        begin
            stamp(frm, t);
            return;
        end
        if (act == fawr_pkg::ACT_RELEASE)
        begin
            busy[frm] = 0;
            return;
        end
        if (act != fawr_pkg::ACT_ALLOC)
            return;
        n = (cnt > fawr_pkg::NUM_FRAMES) ? fawr_pkg::NUM_FRAMES : cnt;
        if (n == 0)
            return;
        foreach (taken[i])
            taken[i] = 0;
        f = 0;
        while (f < fawr_pkg::NUM_FRAMES && busy[f])
            f++;
        while (given.size() < n && f < fawr_pkg::NUM_FRAMES)
        begin
            g.frame_idx = f[3:0];
            g.victim = 0;
            g.err = 0;
            given.insert(given.size(), g);
            taken[f] = 1;
            stamp(f, t);
            f++;
            while (f < fawr_pkg::NUM_FRAMES && busy[f])
                f++;
        end
        if (f >= fawr_pkg::NUM_FRAMES)
        begin
            while (given.size() < n)
            begin
                e = 0;
                if (pol == fawr_pkg::POL_FIFO)
                    f = pick_oldest(taken, e);
                else
                    f = pick_by_value(taken);
                g.frame_idx = f[3:0];
                g.victim = 1;
                g.err = e;
                given.insert(given.size(), g);
                taken[f] = 1;
            end
            foreach (given[k])
            begin
                last_tick[given[k].frame_idx] = t;
                uses[given[k].frame_idx] = 1;
                ring_push(given[k].frame_idx);
            end
        end
        foreach (given[k])
        begin
            busy[given[k].frame_idx] = 1;
            given[k].last = (k == given.size() - 1);
            grants_due.insert(grants_due.size(), given[k]);
        end
    endfunction

    function void check_grant(logic [3:0] fr, logic vic, logic lst, logic er);
        grant_t x;
        if (grants_due.size() == 0)
        begin
            $display("%0t: unexpected grant beat frame=%0d", $time, fr);
            errors++;
            return;
        end
        x = grants_due.pop_front();
        if (fr !== x.frame_idx || vic !== x.victim || lst !== x.last || er !== x.err)
        begin
            $display("%0t: grant mismatch exp frame=%0d vic=%0d last=%0d err=%0d",
                     $time, x.frame_idx, x.victim, x.last, x.err);
            $display("%0t:                got frame=%0d vic=%0d last=%0d err=%0d",
                     $time, fr, vic, lst, er);
            errors++;
        end
    endfunction
endclass

module frame_allocator_with_replacement_core_tb;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [3:0]  frame;
    logic [4:0]  count;
    logic [31:0] tick;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  granted_frame;
    logic        was_victim;
    logic        last_frame;
    logic        error;

    frame_grant_board board;
    int        beats_in;
    int        gap_pct;
    int        stall_pct;
    bit        hold_req;
    bit [31:0] tick_now;

    frame_allocator_with_replacement_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .frame         (frame),
        .count         (count),
        .tick          (tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_frame (granted_frame),
        .was_victim    (was_victim),
        .last_frame    (last_frame),
        .error         (error)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            board.note_beat(fawr_pkg::action_t'(action), frame, count, tick);
            beats_in++;
        end
        if (rst_n && out_valid && out_ready)
            board.check_grant(granted_frame, was_victim, last_frame, error);
    end

    // watchdog: cycles with no beat on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver; a hold request parks out_ready low for a long stretch
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 0;
                repeat (300) @(negedge clk);
                hold_req = 0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after the beat, or later after a random gap
    task automatic send(fawr_pkg::action_t act, int frm, int cnt, bit [31:0] t);
        int n0;
        n0 = beats_in;
        action <= act;
        frame <= frm[3:0];
        count <= cnt[4:0];
        tick <= t;
        in_valid <= 1;
        do
            @(negedge clk);
        while (beats_in == n0);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (board.grants_due.size() != 0)
            @(negedge clk);
        // touches and releases leave no beat behind, so give the core time
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_policy(fawr_pkg::policy_t p);
        wait_drained();
        cfg_we <= 1;
        cfg_wdata <= p;
        @(negedge clk);
        cfg_we <= 0;
        board.pol = p;
    endtask

    function automatic bit [31:0] next_tick();
        if ($urandom_range(19) == 0)
            tick_now = $urandom();
        else
            tick_now = tick_now + $urandom_range(0, 3);
        return tick_now;
    endfunction

    task automatic random_beat();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            send(fawr_pkg::ACT_ALLOC, $urandom_range(15),
                 ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 6),
                 next_tick());
        else if (r < 70)
            send(fawr_pkg::ACT_TOUCH, $urandom_range(15), $urandom_range(31), next_tick());
        else if (r < 95)
            send(fawr_pkg::ACT_RELEASE, $urandom_range(15), $urandom_range(31),
                 next_tick());
        else
            send(fawr_pkg::ACT_NONE, $urandom_range(15), $urandom_range(31), $urandom());
    endtask

    initial
    begin
        fawr_pkg::policy_t order[6];
        board = new();
        beats_in = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        tick_now = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        in_valid = 0;
        action = 0;
        frame = 0;
        count = 0;
        tick = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: field extremes and special cases under reset policy
        send(fawr_pkg::ACT_ALLOC, 0, 0, 32'd0);
        send(fawr_pkg::ACT_ALLOC, 15, 1, 32'd1);
        send(fawr_pkg::ACT_ALLOC, 0, 16, 32'd2);
        send(fawr_pkg::ACT_TOUCH, 15, 0, 32'd3);
        send(fawr_pkg::ACT_TOUCH, 0, 31, 32'd4);
        send(fawr_pkg::ACT_RELEASE, 3, 0, 32'd5);
        send(fawr_pkg::ACT_RELEASE, 3, 0, 32'd5);
        send(fawr_pkg::ACT_NONE, 15, 31, 32'hFFFF_FFFF);
        send(fawr_pkg::ACT_ALLOC, 0, 31, 32'd6);
        send(fawr_pkg::ACT_RELEASE, 0, 0, 32'd7);
        send(fawr_pkg::ACT_RELEASE, 15, 0, 32'd7);
        send(fawr_pkg::ACT_ALLOC, 5, 3, 32'hFFFF_FFFF);
        tick_now = 32'd8;

        // fifo with the ring flooded by one frame: runs the ring dry
        set_policy(fawr_pkg::POL_FIFO);
        send(fawr_pkg::ACT_ALLOC, 0, 16, next_tick());
        repeat (70) send(fawr_pkg::ACT_TOUCH, 0, 0, next_tick());
        send(fawr_pkg::ACT_ALLOC, 0, 16, next_tick());
        send(fawr_pkg::ACT_ALLOC, 0, 16, next_tick());

        order = '{fawr_pkg::POL_LFU, fawr_pkg::POL_MFU, fawr_pkg::POL_LRU,
                  fawr_pkg::POL_FIFO, fawr_pkg::POL_MFU, fawr_pkg::POL_LRU};
        foreach (order[ph])
        begin
            set_policy(order[ph]);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 75; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 75; end
                default: begin gap_pct = 38; stall_pct = 38; end
            endcase
            if (ph == 1)
            begin
                // long receiver hold-off while big requests keep coming
                gap_pct = 0;
                hold_req = 1;
                repeat (5) send(fawr_pkg::ACT_ALLOC, 0, 16, next_tick());
                gap_pct = 75;
            end
            repeat (22) random_beat();
            if (ph == 2)
            begin
                wait_drained();
                repeat (3) send(fawr_pkg::ACT_ALLOC, 0, $urandom_range(1, 16), next_tick());
            end
        end

        wait_drained();
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
